[rtl/scba_pkg.sv]
// Shared types and constants for the size-class bitmap allocator.
// No dependencies; every rtl file refers to it by scoped names.
package scba_pkg;

	localparam int ADDR_W   = 32;
	localparam int BYTES_W  = 24;
	localparam int CFG_W    = 32;
	localparam int NEED_W   = 11;   // request_bytes/16K + 1 fits in 11 bits

	// bitmap scan word
	localparam int SCAN_W   = 8;
	localparam int SCAN_SH  = 3;

	// block sizes as shift amounts and byte thresholds
	localparam int SMALL_SH  = 12;
	localparam int MEDIUM_SH = 13;
	localparam int LARGE_SH  = 14;
	localparam logic [BYTES_W-1:0] SZ_SMALL  = 24'h00_1000;
	localparam logic [BYTES_W-1:0] SZ_MEDIUM = 24'h00_2000;
	localparam logic [BYTES_W-1:0] SZ_LARGE  = 24'h00_4000;

	localparam logic [ADDR_W-1:0] SMALL_BASE_RST  = 32'h0000_0000;
	localparam logic [ADDR_W-1:0] MEDIUM_BASE_RST = 32'h0010_0000;
	localparam logic [ADDR_W-1:0] LARGE_BASE_RST  = 32'h0020_0000;

	// stream packing
	localparam int IN_TDATA_W  = 56;   // request_bytes, free_address
	localparam int OUT_TDATA_W = 40;   // block_address, granted, pad
	localparam int OUT_PAD_W   = 7;

	typedef enum logic [1:0] {
		REG_SMALL_BASE  = 2'd0,
		REG_MEDIUM_BASE = 2'd1,
		REG_LARGE_BASE  = 2'd2
	} reg_idx_t;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		POOL_SMALL  = 3'b001,
		POOL_MEDIUM = 3'b010,
		POOL_LARGE  = 3'b100
	} pool_t;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_SCAN     = 7'b0000010,
		ST_RUN      = 7'b0000100,
		ST_MARK     = 7'b0001000,
		ST_FREE_SEL = 7'b0010000,
		ST_FREE_CLR = 7'b0100000,
		ST_RESP     = 7'b1000000
	} state_t;

endpackage

[rtl/scba_ffz.sv]
// Find-first-zero over one bitmap scan word: the shared search unit.
// Depends on scba_pkg.
module scba_ffz (
	input  logic [scba_pkg::SCAN_W-1:0]  word,
	output logic                         found,
	output logic [scba_pkg::SCAN_SH-1:0] pos
);

	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = scba_pkg::SCAN_W - 1; i >= 0; i--) begin
			if (!word[i]) begin
				found = 1'b1;
				pos   = scba_pkg::SCAN_SH'(i);
			end
		end
	end

endmodule

[rtl/scba_bitmap.sv]
// Used-bit map of one block pool: word read port, one set and one clear port.
// Depends on scba_pkg. Bits past the pool end read as used.
module scba_bitmap #(
	parameter  int BLOCKS = 256,
	localparam int WORDS  = (BLOCKS + scba_pkg::SCAN_W - 1) / scba_pkg::SCAN_W,
	localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1,
	localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [WIDX_W-1:0]            rd_word,
	output logic [scba_pkg::SCAN_W-1:0]  word,
	input  logic                         set_en,
	input  logic [IDX_W-1:0]             set_idx,
	input  logic                         clr_en,
	input  logic [IDX_W-1:0]             clr_idx
);

	logic [BLOCKS-1:0]                 used_q;
	logic [WORDS*scba_pkg::SCAN_W-1:0] padded;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (set_en)
				used_q[set_idx] <= 1'b1;
			if (clr_en)
				used_q[clr_idx] <= 1'b0;
		end
	end

	always_comb begin
		padded = '1;
		padded[BLOCKS-1:0] = used_q;
	end

	assign word = padded[rd_word*scba_pkg::SCAN_W +: scba_pkg::SCAN_W];

endmodule

[rtl/size_class_bitmap_allocator_unit.sv]
// Size-class bitmap allocator, top level: request sequencer, pool bitmaps, output register.
// Allocate: one 8-bit bitmap word is scanned per cycle; a large run scans the large pool one bit
// per cycle, then marks one bit per cycle. One request at a time; the next is taken once the
// result is loaded into the output register. Reset clears all used bits and loads the default
// pool bases.
module size_class_bitmap_allocator_unit #(
	parameter int SMALL_BLOCKS  = 256,
	parameter int MEDIUM_BLOCKS = 128,
	parameter int LARGE_BLOCKS  = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [scba_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // request_bytes, free_address
	input  logic                               s_axis_tuser,  // opcode
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [scba_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // block_address, granted, pad
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [scba_pkg::CFG_W-1:0]         cfg_data
);

	localparam int SW    = (SMALL_BLOCKS + scba_pkg::SCAN_W - 1) / scba_pkg::SCAN_W;
	localparam int MW    = (MEDIUM_BLOCKS + scba_pkg::SCAN_W - 1) / scba_pkg::SCAN_W;
	localparam int LW    = (LARGE_BLOCKS + scba_pkg::SCAN_W - 1) / scba_pkg::SCAN_W;
	localparam int SWW   = (SW > 1) ? $clog2(SW) : 1;
	localparam int MWW   = (MW > 1) ? $clog2(MW) : 1;
	localparam int LWW   = (LW > 1) ? $clog2(LW) : 1;
	localparam int SIW   = (SMALL_BLOCKS > 1) ? $clog2(SMALL_BLOCKS) : 1;
	localparam int MIW   = (MEDIUM_BLOCKS > 1) ? $clog2(MEDIUM_BLOCKS) : 1;
	localparam int LIW   = (LARGE_BLOCKS > 1) ? $clog2(LARGE_BLOCKS) : 1;
	localparam int MAXN0 = (SMALL_BLOCKS > MEDIUM_BLOCKS) ? SMALL_BLOCKS : MEDIUM_BLOCKS;
	localparam int MAXN  = (MAXN0 > LARGE_BLOCKS) ? MAXN0 : LARGE_BLOCKS;
	localparam int CW    = $clog2(MAXN + 1);
	localparam int XW    = CW + scba_pkg::SCAN_SH;

	scba_pkg::state_t state_q, state_d;
	scba_pkg::pool_t  pool_q;
	scba_pkg::pool_t  pool_in;

	logic [scba_pkg::ADDR_W-1:0]  small_base_q, medium_base_q, large_base_q;
	logic [scba_pkg::ADDR_W-1:0]  free_addr_q, res_q;
	logic                         grant_q;
	logic [CW-1:0]                cnt_q, mark_q, start_q;
	logic [scba_pkg::NEED_W-1:0]  need_q, run_q;
	logic                         out_valid_q, out_grant_q;
	logic [scba_pkg::ADDR_W-1:0]  out_addr_q;

	logic                         s_acc, resp_load;
	logic                         in_op;
	logic [scba_pkg::BYTES_W-1:0] in_bytes;
	logic [scba_pkg::ADDR_W-1:0]  in_addr;
	logic [scba_pkg::NEED_W-1:0]  need_in;
	logic                         need_big;

	logic [scba_pkg::SCAN_W-1:0]  small_word, medium_word, large_word, scan_word;
	logic                         ff_found;
	logic [scba_pkg::SCAN_SH-1:0] ff_pos;
	logic [XW-1:0]                scan_idx;
	logic                         scan_last;
	logic [scba_pkg::ADDR_W-1:0]  scan_addr;
	logic [CW-1:0]                run_wordidx;
	logic [LWW-1:0]               l_rd;

	logic                         run_bit, run_hit;
	logic [scba_pkg::NEED_W-1:0]  run_next;
	logic [CW-1:0]                run_start;

	logic [scba_pkg::ADDR_W:0]    small_end, medium_end;
	logic [scba_pkg::ADDR_W-1:0]  f_base, f_off, f_count;
	logic                         f_in;

	logic s_set, m_set, l_set, s_clr, m_clr, l_clr;
	logic [LIW-1:0] l_set_idx;

	assign in_op    = s_axis_tuser;
	assign in_bytes = s_axis_tdata[scba_pkg::BYTES_W-1:0];
	assign in_addr  = s_axis_tdata[scba_pkg::BYTES_W +: scba_pkg::ADDR_W];

	assign s_axis_tready = (state_q == scba_pkg::ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign resp_load     = (state_q == scba_pkg::ST_RESP) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{scba_pkg::OUT_PAD_W{1'b0}}, out_grant_q, out_addr_q};

	// class choice and run length
	assign need_in  = scba_pkg::NEED_W'(in_bytes >> scba_pkg::LARGE_SH) + 1'b1;
	assign need_big = 32'(need_in) > 32'(LARGE_BLOCKS);

	always_comb begin
		if (in_bytes <= scba_pkg::SZ_SMALL)
			pool_in = scba_pkg::POOL_SMALL;
		else if (in_bytes <= scba_pkg::SZ_MEDIUM)
			pool_in = scba_pkg::POOL_MEDIUM;
		else
			pool_in = scba_pkg::POOL_LARGE;
	end

	// ---- bitmaps and shared search unit ----
	assign run_wordidx = cnt_q >> scba_pkg::SCAN_SH;
	assign l_rd = (state_q == scba_pkg::ST_RUN) ? run_wordidx[LWW-1:0] : cnt_q[LWW-1:0];

	scba_bitmap #(.BLOCKS(SMALL_BLOCKS)) u_small (
		.clk(clk), .arst_n(arst_n),
		.rd_word(cnt_q[SWW-1:0]), .word(small_word),
		.set_en(s_set), .set_idx(scan_idx[SIW-1:0]),
		.clr_en(s_clr), .clr_idx(f_off[SIW-1:0])
	);

	scba_bitmap #(.BLOCKS(MEDIUM_BLOCKS)) u_medium (
		.clk(clk), .arst_n(arst_n),
		.rd_word(cnt_q[MWW-1:0]), .word(medium_word),
		.set_en(m_set), .set_idx(scan_idx[MIW-1:0]),
		.clr_en(m_clr), .clr_idx(f_off[MIW-1:0])
	);

	scba_bitmap #(.BLOCKS(LARGE_BLOCKS)) u_large (
		.clk(clk), .arst_n(arst_n),
		.rd_word(l_rd), .word(large_word),
		.set_en(l_set), .set_idx(l_set_idx),
		.clr_en(l_clr), .clr_idx(f_off[LIW-1:0])
	);

	always_comb begin
		unique case (pool_q)
			scba_pkg::POOL_SMALL: begin
				scan_word = small_word;
				scan_last = (cnt_q == CW'(SW - 1));
				scan_addr = small_base_q + (32'(scan_idx) << scba_pkg::SMALL_SH);
			end
			scba_pkg::POOL_MEDIUM: begin
				scan_word = medium_word;
				scan_last = (cnt_q == CW'(MW - 1));
				scan_addr = medium_base_q + (32'(scan_idx) << scba_pkg::MEDIUM_SH);
			end
			default: begin
				scan_word = large_word;
				scan_last = (cnt_q == CW'(LW - 1));
				scan_addr = large_base_q + (32'(scan_idx) << scba_pkg::LARGE_SH);
			end
		endcase
	end

	scba_ffz u_ffz (
		.word(scan_word),
		.found(ff_found),
		.pos(ff_pos)
	);

	assign scan_idx = {cnt_q, ff_pos};

	// run search: one large-pool bit per cycle, run ends at cnt_q
	assign run_bit   = large_word[cnt_q[scba_pkg::SCAN_SH-1:0]];
	assign run_next  = run_q + 1'b1;
	assign run_hit   = !run_bit && (run_next == need_q);
	assign run_start = cnt_q - CW'(need_q) + 1'b1;

	// free: pool by end bounds, then block offset
	assign small_end  = {1'b0, small_base_q} + ((scba_pkg::ADDR_W+1)'(SMALL_BLOCKS)
		<< scba_pkg::SMALL_SH);
	assign medium_end = {1'b0, medium_base_q} + ((scba_pkg::ADDR_W+1)'(MEDIUM_BLOCKS)
		<< scba_pkg::MEDIUM_SH);

	always_comb begin
		unique case (pool_q)
			scba_pkg::POOL_SMALL: begin
				f_base  = small_base_q;
				f_off   = (free_addr_q - small_base_q) >> scba_pkg::SMALL_SH;
				f_count = 32'(SMALL_BLOCKS);
			end
			scba_pkg::POOL_MEDIUM: begin
				f_base  = medium_base_q;
				f_off   = (free_addr_q - medium_base_q) >> scba_pkg::MEDIUM_SH;
				f_count = 32'(MEDIUM_BLOCKS);
			end
			default: begin
				f_base  = large_base_q;
				f_off   = (free_addr_q - large_base_q) >> scba_pkg::LARGE_SH;
				f_count = 32'(LARGE_BLOCKS);
			end
		endcase
	end

	assign f_in = (free_addr_q >= f_base) && (f_off < f_count);

	assign s_set = (state_q == scba_pkg::ST_SCAN) && (pool_q == scba_pkg::POOL_SMALL) && ff_found;
	assign m_set = (state_q == scba_pkg::ST_SCAN) && (pool_q == scba_pkg::POOL_MEDIUM) && ff_found;
	assign l_set = ((state_q == scba_pkg::ST_SCAN) && (pool_q == scba_pkg::POOL_LARGE) && ff_found)
		|| (state_q == scba_pkg::ST_MARK);
	assign l_set_idx = (state_q == scba_pkg::ST_MARK) ? mark_q[LIW-1:0] : scan_idx[LIW-1:0];

	assign s_clr = (state_q == scba_pkg::ST_FREE_CLR) && (pool_q == scba_pkg::POOL_SMALL) && f_in;
	assign m_clr = (state_q == scba_pkg::ST_FREE_CLR) && (pool_q == scba_pkg::POOL_MEDIUM) && f_in;
	assign l_clr = (state_q == scba_pkg::ST_FREE_CLR) && (pool_q == scba_pkg::POOL_LARGE) && f_in;

	// ---- sequencer ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scba_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (in_op == scba_pkg::OP_FREE)
						state_d = scba_pkg::ST_FREE_SEL;
					else if (in_bytes <= scba_pkg::SZ_LARGE)
						state_d = scba_pkg::ST_SCAN;
					else if (need_big)
						state_d = scba_pkg::ST_RESP;
					else
						state_d = scba_pkg::ST_RUN;
				end
			end
			scba_pkg::ST_SCAN: begin
				if (ff_found || scan_last)
					state_d = scba_pkg::ST_RESP;
			end
			scba_pkg::ST_RUN: begin
				if (run_hit)
					state_d = scba_pkg::ST_MARK;
				else if (cnt_q == CW'(LARGE_BLOCKS - 1))
					state_d = scba_pkg::ST_RESP;
			end
			scba_pkg::ST_MARK: begin
				if (mark_q == cnt_q)
					state_d = scba_pkg::ST_RESP;
			end
			scba_pkg::ST_FREE_SEL: state_d = scba_pkg::ST_FREE_CLR;
			scba_pkg::ST_FREE_CLR: state_d = scba_pkg::ST_RESP;
			scba_pkg::ST_RESP: begin
				if (resp_load)
					state_d = scba_pkg::ST_IDLE;
			end
			default: state_d = scba_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= scba_pkg::ST_IDLE;
			out_valid_q   <= 1'b0;
			small_base_q  <= scba_pkg::SMALL_BASE_RST;
			medium_base_q <= scba_pkg::MEDIUM_BASE_RST;
			large_base_q  <= scba_pkg::LARGE_BASE_RST;
		end else begin
			state_q <= state_d;
			if (resp_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					scba_pkg::REG_SMALL_BASE:  small_base_q  <= cfg_data;
					scba_pkg::REG_MEDIUM_BASE: medium_base_q <= cfg_data;
					scba_pkg::REG_LARGE_BASE:  large_base_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			scba_pkg::ST_IDLE: begin
				if (s_acc) begin
					free_addr_q <= in_addr;
					need_q      <= need_in;
					pool_q      <= pool_in;
					cnt_q       <= '0;
					run_q       <= '0;
					grant_q     <= 1'b0;
					res_q       <= '0;
				end
			end
			scba_pkg::ST_SCAN: begin
				if (ff_found) begin
					grant_q <= 1'b1;
					res_q   <= scan_addr;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			scba_pkg::ST_RUN: begin
				run_q <= run_bit ? '0 : run_next;
				if (run_hit) begin
					mark_q  <= run_start;
					start_q <= run_start;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			scba_pkg::ST_MARK: begin
				if (mark_q == cnt_q) begin
					grant_q <= 1'b1;
					res_q   <= large_base_q + (32'(start_q) << scba_pkg::LARGE_SH);
				end else begin
					mark_q <= mark_q + 1'b1;
				end
			end
			scba_pkg::ST_FREE_SEL: begin
				if ({1'b0, free_addr_q} < small_end)
					pool_q <= scba_pkg::POOL_SMALL;
				else if ({1'b0, free_addr_q} < medium_end)
					pool_q <= scba_pkg::POOL_MEDIUM;
				else
					pool_q <= scba_pkg::POOL_LARGE;
			end
			default: ;
		endcase

		if (resp_load) begin
			out_addr_q  <= res_q;
			out_grant_q <= grant_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[scba_pkg::ADDR_W]
		|-> m_axis_tdata[scba_pkg::ADDR_W-1:0] == '0)
		else $error("failed request carries a nonzero address");

	a_one_map_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({s_set, s_clr, m_set, m_clr, l_set, l_clr}))
		else $error("more than one bitmap update in a cycle");

	a_run_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == scba_pkg::ST_RUN |-> run_q < need_q)
		else $error("free-run count reached the need without a hit");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while the previous one is in work");
`endif

endmodule
